FILE: src/tcc_pkg.sv
// shared types and constants of the text console cursor engine
// no dependencies; imported by the top level and tcc_sweep
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int NIB_W  = 4;
    localparam int IDX_W  = 11;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0520;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_CRD,
        ST_CWR,
        ST_BLANK,
        ST_DONE
    } state_t;

    // controls for the address sweep unit
    typedef struct packed {
        logic load;
        logic step;
        logic row_ofs;
    } sweep_ctrl_t;

endpackage

FILE: src/text_console_cursor_engine.sv
// top level of the text console cursor engine: command sequencer, cursor
// and result register; uses tcc_pkg, tcc_ram and tcc_sweep
`timescale 1ns / 1ps

// character cell terminal of COLUMNS x ROWS 16-bit cells
//
// input channel (in_valid / in_ready): one beat is one command with cmd,
// char_code, bg_color, fg_color and cell_index. put writes printable
// bytes and moves the cursor, clear blanks the screen and homes the cursor,
// read returns one cell. output channel (out_valid / out_ready): one beat per
// command with the linear cursor position and, for a read, the cell data.
//
// a put that scrolls copies every row but the top one up by a row, then
// blanks the bottom row. the cell store has one write and one read port,
// so a scroll moves each cell by a read, then a write, and a blank writes
// one cell per cycle.
// one command is in flight at a time; in_ready is high only while idle.
// a result sits in an output register, so a new command is accepted while
// the receiver stalls; its own result then waits until the register frees.
//
// reset: cursor homes and a clearing pass writes blank 0x0520 to all
// COLUMNS*ROWS cells, one per cycle, with in_ready held low.
module text_console_cursor_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tcc_pkg::CMD_W-1:0]     cmd,
    input  logic [tcc_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcc_pkg::NIB_W-1:0]     bg_color,
    input  logic [tcc_pkg::NIB_W-1:0]     fg_color,
    input  logic [tcc_pkg::IDX_W-1:0]     cell_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcc_pkg::LOC_W-1:0]     cursor_location,
    output logic [tcc_pkg::CELL_W-1:0]    read_data
);

    import tcc_pkg::*;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    // column must hold the tab overshoot before the wrap check
    localparam int COL_W     = $clog2(COLUMNS + 8);
    // row must hold ROWS before the scroll check
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int BOTTOM    = (ROWS - 1) * COLUMNS;
    localparam int COPY_LAST = BOTTOM - 1;

    // sequencer state
    state_t state_reg, state_next;

    // cursor
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // latched command
    logic [CMD_W-1:0]   cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [2*NIB_W-1:0] attr_reg;
    logic [IDX_W-1:0]   idx_reg;

    // result under construction and the output register
    logic [CELL_W-1:0] data_reg, data_next;
    logic              out_valid_reg, out_valid_next;
    logic [LOC_W-1:0]  loc_reg, loc_next;
    logic [CELL_W-1:0] rdout_reg, rdout_next;
    logic              out_load;

    // cell store ports
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    // sweep unit
    sweep_ctrl_t       sw_ctrl;
    logic [ADDR_W-1:0] sw_load_addr;
    logic [ADDR_W-1:0] sw_last_addr;
    logic [ADDR_W-1:0] sw_cnt;
    logic [ADDR_W-1:0] sw_sum;
    logic              sw_last;

    // put-character evaluation
    logic [COL_W-1:0]  put_col_a;
    logic [ROW_W-1:0]  put_row_a;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              put_print;
    logic              put_scroll;
    logic [ADDR_W-1:0] cur_pos;
    logic              cur_in_range;
    logic              idx_in_range;
    logic [ADDR_W-1:0] idx_addr;

    tcc_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcc_sweep #(
        .ADDR_W  (ADDR_W),
        .COLUMNS (COLUMNS)
    ) u_sweep (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sw_ctrl),
        .load_addr (sw_load_addr),
        .last_addr (sw_last_addr),
        .cnt       (sw_cnt),
        .sum       (sw_sum),
        .last      (sw_last)
    );

    assign in_ready = (state_reg == ST_IDLE);

    // linear cursor position; row and column stay in range outside a put
    assign cur_pos      = ADDR_W'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign cur_in_range = (int'(row_reg) * COLUMNS + int'(col_reg)) < CELLS;
    assign idx_in_range = int'(idx_reg) < CELLS;
    assign idx_addr     = ADDR_W'(idx_reg);

    // cursor motion of a put command
    always_comb
    begin
        put_col_a = col_reg;
        put_row_a = row_reg;
        put_print = 1'b0;
        priority if (char_reg == CH_BS)
        begin
            // no move at column zero
            if (col_reg != '0)
            begin
                put_col_a = col_reg - 1'b1;
            end
        end
        else if (char_reg == CH_TAB)
        begin
            put_col_a = {col_reg[COL_W-1:3] + 1'b1, 3'b000};
        end
        else if (char_reg == CH_CR)
        begin
            put_col_a = '0;
        end
        else if (char_reg == CH_LF)
        begin
            put_col_a = '0;
            put_row_a = row_reg + 1'b1;
        end
        else if (char_reg >= CH_PRINT_LO && char_reg <= CH_PRINT_HI)
        begin
            put_print = 1'b1;
            put_col_a = col_reg + 1'b1;
        end
        else
        begin
            // other control bytes and the high half are ignored
            put_print = 1'b0;
        end

        // line wrap
        if (put_col_a >= COL_W'(COLUMNS))
        begin
            put_col = '0;
            put_row = put_row_a + 1'b1;
        end
        else
        begin
            put_col = put_col_a;
            put_row = put_row_a;
        end

        put_scroll = (put_row >= ROW_W'(ROWS));
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        data_next    = data_reg;
        mem_we       = 1'b0;
        mem_waddr    = sw_cnt;
        mem_wdata    = BLANK_CELL;
        mem_re       = 1'b0;
        mem_raddr    = sw_sum;
        sw_ctrl      = '0;
        sw_load_addr = '0;
        sw_last_addr = ADDR_W'(CELLS - 1);
        out_load     = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                // blank pass after reset, last cell of the store ends it
                mem_we       = 1'b1;
                sw_ctrl.step = 1'b1;
                if (sw_cnt == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                data_next = '0;
                unique case (cmd_reg)
                    CMD_PUT:
                    begin
                        mem_we    = put_print && cur_in_range;
                        mem_waddr = cur_pos;
                        mem_wdata = {attr_reg, char_reg};
                        col_next  = put_col;
                        if (put_scroll)
                        begin
                            row_next     = ROW_W'(ROWS - 1);
                            sw_ctrl.load = 1'b1;
                            sw_load_addr = '0;
                            sw_last_addr = ADDR_W'(COPY_LAST);
                            state_next   = ST_CRD;
                        end
                        else
                        begin
                            row_next   = put_row;
                            state_next = ST_DONE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        col_next     = '0;
                        row_next     = '0;
                        sw_ctrl.load = 1'b1;
                        sw_load_addr = '0;
                        sw_last_addr = ADDR_W'(CELLS - 1);
                        state_next   = ST_BLANK;
                    end
                    CMD_READ:
                    begin
                        if (idx_in_range)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = idx_addr;
                            state_next = ST_RDWAIT;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        // unused command: result only
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                data_next  = mem_rdata;
                state_next = ST_DONE;
            end
            ST_CRD:
            begin
                // fetch the cell one row below
                mem_re          = 1'b1;
                sw_ctrl.row_ofs = 1'b1;
                mem_raddr       = sw_sum;
                state_next      = ST_CWR;
            end
            ST_CWR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (sw_last)
                begin
                    // bottom row gets blanked next
                    sw_ctrl.load = 1'b1;
                    sw_load_addr = ADDR_W'(BOTTOM);
                    sw_last_addr = ADDR_W'(CELLS - 1);
                    state_next   = ST_BLANK;
                end
                else
                begin
                    sw_ctrl.step = 1'b1;
                    state_next   = ST_CRD;
                end
            end
            ST_BLANK:
            begin
                mem_we       = 1'b1;
                sw_ctrl.step = 1'b1;
                if (sw_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        loc_next       = loc_reg;
        rdout_next     = rdout_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            loc_next       = LOC_W'(int'(row_reg) * COLUMNS + int'(col_reg));
            rdout_next     = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            char_reg <= char_code;
            attr_reg <= {bg_color, fg_color};
            idx_reg  <= cell_index;
        end
        data_reg  <= data_next;
        loc_reg   <= loc_next;
        rdout_reg <= rdout_next;
    end

    assign out_valid       = out_valid_reg;
    assign cursor_location = loc_reg;
    assign read_data       = rdout_reg;

`ifndef SYNTHESIS
    // cursor is back in range whenever a command may enter
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (row_reg < ROW_W'(ROWS) && col_reg < COL_W'(COLUMNS)))
        else $error("cursor out of range while idle");

    // the cell store is never written while idle or waiting on the output
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE && state_reg != ST_DONE))
        else $error("cell write outside a command");

    // a new result comes only from the done step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done step");

    // scroll copy stays above the bottom row
    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CWR) |-> (int'(sw_cnt) <= COPY_LAST))
        else $error("scroll copy beyond the bottom row");
`endif

endmodule

FILE: src/tcc_ram.sv
// single write port, single read port cell store with registered read data
// depends on nothing but its parameters
`timescale 1ns / 1ps

module tcc_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tcc_sweep.sv
// address sweep unit: cell counter, end mark and one shared adder
// depends on tcc_pkg for the control struct
`timescale 1ns / 1ps

module tcc_sweep #(
    parameter int ADDR_W  = 11,
    parameter int COLUMNS = 80
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcc_pkg::sweep_ctrl_t ctrl,
    input  logic [ADDR_W-1:0]    load_addr,
    input  logic [ADDR_W-1:0]    last_addr,
    output logic [ADDR_W-1:0]    cnt,
    output logic [ADDR_W-1:0]    sum,
    output logic                 last
);

    import tcc_pkg::*;

    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] last_reg;

    // one adder: next cell, or the cell one row below
    assign sum  = cnt_reg + (ctrl.row_ofs ? ADDR_W'(COLUMNS) : ADDR_W'(1));
    assign cnt  = cnt_reg;
    assign last = (cnt_reg == last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            last_reg <= ADDR_W'(0) - ADDR_W'(1);
        end
        else if (ctrl.load)
        begin
            cnt_reg  <= load_addr;
            last_reg <= last_addr;
        end
        else if (ctrl.step)
        begin
            cnt_reg <= sum;
        end
    end

endmodule
